@@ hw/rtl/mitu_pkg.sv @@
`default_nettype none
package mitu_pkg;

    // opcodes
    localparam logic [5:0] OP_REGIMM = 6'h01;
    localparam logic [5:0] OP_BEQ    = 6'h04;
    localparam logic [5:0] OP_BNE    = 6'h05;
    localparam logic [5:0] OP_BLEZ   = 6'h06;
    localparam logic [5:0] OP_BGTZ   = 6'h07;
    localparam logic [5:0] OP_ADDI   = 6'h08;
    localparam logic [5:0] OP_ADDIU  = 6'h09;
    localparam logic [5:0] OP_SLTI   = 6'h0A;
    localparam logic [5:0] OP_SLTIU  = 6'h0B;
    localparam logic [5:0] OP_ANDI   = 6'h0C;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_XORI   = 6'h0E;
    localparam logic [5:0] OP_LUI    = 6'h0F;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LH     = 6'h21;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_LBU    = 6'h24;
    localparam logic [5:0] OP_LHU    = 6'h25;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SH     = 6'h29;
    localparam logic [5:0] OP_SW     = 6'h2B;

    // REGIMM rt codes
    localparam logic [4:0] RI_BLTZ   = 5'd0;
    localparam logic [4:0] RI_BGEZ   = 5'd1;
    localparam logic [4:0] RI_BLTZAL = 5'd16;
    localparam logic [4:0] RI_BGEZAL = 5'd17;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;
    localparam logic [1:0] ST_INV  = 2'd3;

    // access sizes
    localparam logic [1:0] SZ_NONE = 2'd0;
    localparam logic [1:0] SZ_BYTE = 2'd1;
    localparam logic [1:0] SZ_HALF = 2'd2;
    localparam logic [1:0] SZ_WORD = 2'd3;

    // config register indexes
    localparam logic CFG_DATA_BASE = 1'b0;
    localparam logic CFG_INST_BASE = 1'b1;

    localparam logic [31:0] DATA_BASE_RST = 32'h2000_0000;
    localparam logic [31:0] INST_BASE_RST = 32'h1000_0000;
    localparam logic [31:0] PC_RST        = 32'h1000_0000;
    localparam logic [31:0] GETC_ADDR     = 32'h3000_0000;
    localparam logic [31:0] PUTC_ADDR     = 32'h3000_0004;
    localparam logic [7:0]  CHAR_NEWLINE  = 8'd10;
    localparam logic [4:0]  LINK_REG      = 5'd31;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instr_word;
        logic [11:0] fill_index;
        logic [31:0] fill_word;
        logic [7:0]  char_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic        branch_taken;
        logic [31:0] slot_addr;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        char_valid;
        logic [7:0]  char_out;
    } t_out_item;

endpackage
`default_nettype wire

@@ hw/rtl/mitu_ram.sv @@
`default_nettype none
module mitu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mips_itype_execute_unit.sv @@
`default_nettype none
// Register file read at accept, memory read in the next cycle, then register file
// and memory write-back in stage C as the result enters the output register; no new
// item is accepted while one is in stage B or while stage C waits on the output.
// Reset (synchronous, active low) loads PC and base registers with their reset values
// and clears pipeline control, then sweeps data memory to zero with input ready held low.
module mips_itype_execute_unit #(
    parameter int DATA_WORDS = 4096,
    parameter int INST_WORDS = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire mitu_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output mitu_pkg::t_out_item       o_out
);
    import mitu_pkg::*;

    localparam int DAW = $clog2(DATA_WORDS);
    localparam int IAW = $clog2(INST_WORDS);
    localparam logic [32:0] DATA_LIM = 33'(DATA_WORDS);
    localparam logic [32:0] INST_LIM = 33'(INST_WORDS);

    // control / config
    logic [31:0] r_data_base, r_inst_base, r_pc;
    logic        r_b_valid, r_c_valid, r_out_valid;
    logic        r_clr_busy;
    logic [DAW-1:0] r_clr_idx;
    logic [31:0] r_rvld;
    logic        r_fw_vld;
    logic [4:0]  r_fw_idx;
    logic [31:0] r_fw_val;
    t_out_item   r_out;

    // stage B / C payload
    t_in_item    r_b;
    t_in_item    r_c;
    logic [31:0] r_c_a, r_c_b, r_c_ea;
    logic        r_c_data_ok, r_c_inst_ok;
    logic [DAW-1:0] r_c_daddr;

    logic in_acc, c_done;

    // ram ports
    logic [31:0] rf_a_q, rf_b_q, dm_q, im_q;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        dm_we;
    logic [DAW-1:0] dm_waddr;
    logic [31:0] dm_wdata;
    logic        im_we;

    // stage B
    logic [4:0]  b_rs, b_rt;
    logic [31:0] b_simm, b_a, b_b, b_ea, b_off_d, b_off_i;
    logic        b_in_data, b_data_ok, b_inst_ok;

    // stage C
    logic [5:0]  c_op;
    logic [4:0]  c_rs, c_rt, c_dst;
    logic [31:0] c_uimm, c_simm, c_sum, c_val, c_npc, c_ldw, c_ld, c_stw;
    logic [1:0]  c_status, c_size;
    logic        c_cond_vld, c_cond, c_link, c_dowr, c_load, c_store;
    logic        c_putc, c_mem_st;
    logic [31:0] c_fill32;
    logic        c_fill_ok;
    t_out_item   c_res;

    assign in_acc     = i_in_valid && o_in_ready;
    assign c_done     = r_c_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && !r_b_valid && (!r_c_valid || c_done);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- memories ----------------
    mitu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk, .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_re(in_acc), .i_raddr(i_in.instr_word[25:21]), .o_rdata(rf_a_q)
    );
    mitu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk, .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_re(in_acc), .i_raddr(i_in.instr_word[20:16]), .o_rdata(rf_b_q)
    );
    mitu_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk, .i_we(dm_we), .i_waddr(dm_waddr), .i_wdata(dm_wdata),
        .i_re(r_b_valid), .i_raddr(b_off_d[DAW+1:2]), .o_rdata(dm_q)
    );
    mitu_ram #(.WIDTH(32), .DEPTH(INST_WORDS)) u_imem (
        .i_clk, .i_we(im_we), .i_waddr(c_fill32[IAW-1:0]), .i_wdata(r_c.fill_word),
        .i_re(r_b_valid), .i_raddr(b_off_i[IAW+1:2]), .o_rdata(im_q)
    );

    // ---------------- stage B: operands, address, region ----------------
    always_comb begin
        b_rs   = r_b.instr_word[25:21];
        b_rt   = r_b.instr_word[20:16];
        b_simm = {{16{r_b.instr_word[15]}}, r_b.instr_word[15:0]};
        // forward the latest commit, since it may land on the read edge
        if (b_rs == 5'd0) b_a = '0;
        else if (r_fw_vld && r_fw_idx == b_rs) b_a = r_fw_val;
        else if (r_rvld[b_rs]) b_a = rf_a_q;
        else b_a = '0;
        if (b_rt == 5'd0) b_b = '0;
        else if (r_fw_vld && r_fw_idx == b_rt) b_b = r_fw_val;
        else if (r_rvld[b_rt]) b_b = rf_b_q;
        else b_b = '0;
        b_ea      = b_a + b_simm;
        b_off_d   = b_ea - r_data_base;
        b_off_i   = b_ea - r_inst_base;
        b_in_data = b_ea >= r_data_base;
        b_data_ok = b_in_data && ({3'b000, b_off_d[31:2]} < DATA_LIM);
        b_inst_ok = !b_in_data && (b_ea >= r_inst_base)
                    && ({3'b000, b_off_i[31:2]} < INST_LIM);
    end

    // ---------------- stage C: execute and commit ----------------
    always_comb begin
        c_op    = r_c.instr_word[31:26];
        c_rs    = r_c.instr_word[25:21];
        c_rt    = r_c.instr_word[20:16];
        c_uimm  = {16'h0000, r_c.instr_word[15:0]};
        c_simm  = {{16{r_c.instr_word[15]}}, r_c.instr_word[15:0]};
        c_sum   = r_c_a + c_simm;
        c_status   = ST_OK;
        c_cond_vld = 1'b0;
        c_cond     = 1'b0;
        c_link     = 1'b0;
        c_dowr     = 1'b0;
        c_dst      = c_rt;
        c_val      = '0;
        c_size     = SZ_NONE;
        c_load     = 1'b0;
        c_store    = 1'b0;
        c_putc     = 1'b0;
        c_mem_st   = 1'b0;
        c_ldw      = r_c_data_ok ? dm_q : im_q;
        c_ld       = '0;
        c_stw      = dm_q;
        c_npc      = r_pc + 32'd4;

        unique case (c_op)
            OP_REGIMM: begin
                if (c_rt == RI_BLTZ || c_rt == RI_BLTZAL) begin
                    c_cond_vld = 1'b1;
                    c_cond     = r_c_a[31];
                end else if (c_rt == RI_BGEZ || c_rt == RI_BGEZAL) begin
                    c_cond_vld = 1'b1;
                    c_cond     = !r_c_a[31];
                end else begin
                    c_status = ST_INV;
                end
                c_link = (c_rt == RI_BLTZAL) || (c_rt == RI_BGEZAL);
            end
            OP_BEQ: begin
                c_cond_vld = 1'b1;
                c_cond     = (r_c_a == r_c_b);
            end
            OP_BNE: begin
                c_cond_vld = 1'b1;
                c_cond     = (r_c_a != r_c_b);
            end
            OP_BLEZ: begin
                if (c_rt == 5'd0) begin
                    c_cond_vld = 1'b1;
                    c_cond     = r_c_a[31] || (r_c_a == '0);
                end else c_status = ST_INV;
            end
            OP_BGTZ: begin
                if (c_rt == 5'd0) begin
                    c_cond_vld = 1'b1;
                    c_cond     = !r_c_a[31] && (r_c_a != '0);
                end else c_status = ST_INV;
            end
            OP_ADDI: begin
                c_val = c_sum;
                if (((r_c_a ^ c_sum) & (c_simm ^ c_sum)) >> 31 != '0) c_status = ST_OVF;
                else c_dowr = 1'b1;
            end
            OP_ADDIU: begin
                c_val  = c_sum;
                c_dowr = 1'b1;
            end
            OP_SLTI: begin
                c_val  = {31'd0, $signed(r_c_a) < $signed(c_simm)};
                c_dowr = 1'b1;
            end
            OP_SLTIU: begin
                c_val  = {31'd0, r_c_a < c_simm};
                c_dowr = 1'b1;
            end
            OP_ANDI: begin
                c_val  = r_c_a & c_uimm;
                c_dowr = 1'b1;
            end
            OP_ORI: begin
                c_val  = r_c_a | c_uimm;
                c_dowr = 1'b1;
            end
            OP_XORI: begin
                c_val  = r_c_a ^ c_uimm;
                c_dowr = 1'b1;
            end
            OP_LUI: begin
                if (c_rs == 5'd0) begin
                    c_val  = {r_c.instr_word[15:0], 16'h0000};
                    c_dowr = 1'b1;
                end else c_status = ST_INV;
            end
            OP_LB, OP_LBU: begin
                c_size = SZ_BYTE;
                c_load = 1'b1;
            end
            OP_LH, OP_LHU: begin
                c_size = SZ_HALF;
                c_load = 1'b1;
            end
            OP_LW: begin
                c_size = SZ_WORD;
                c_load = 1'b1;
            end
            OP_SB: begin
                c_size  = SZ_BYTE;
                c_store = 1'b1;
            end
            OP_SH: begin
                c_size  = SZ_HALF;
                c_store = 1'b1;
            end
            OP_SW: begin
                c_size  = SZ_WORD;
                c_store = 1'b1;
            end
            default: c_status = ST_INV;
        endcase

        if ((c_size == SZ_HALF && r_c_ea[0]) ||
            (c_size == SZ_WORD && r_c_ea[1:0] != 2'b00)) begin
            c_status = ST_ADDR;
        end

        if (c_status == ST_OK && c_load) begin
            if (r_c_ea[31:2] == GETC_ADDR[31:2]) begin
                c_ld = (r_c.char_in == CHAR_NEWLINE) ? '1 : {24'd0, r_c.char_in};
            end else if (!r_c_data_ok && !r_c_inst_ok) begin
                c_status = ST_ADDR;
            end else begin
                unique case (c_size)
                    SZ_BYTE: begin
                        unique case (r_c_ea[1:0])
                            2'd0: c_ld = {24'd0, c_ldw[31:24]};
                            2'd1: c_ld = {24'd0, c_ldw[23:16]};
                            2'd2: c_ld = {24'd0, c_ldw[15:8]};
                            default: c_ld = {24'd0, c_ldw[7:0]};
                        endcase
                    end
                    SZ_HALF: c_ld = r_c_ea[1] ? {16'd0, c_ldw[15:0]}
                                              : {16'd0, c_ldw[31:16]};
                    default: c_ld = c_ldw;
                endcase
            end
            if (c_op == OP_LB && c_ld[7])  c_ld = c_ld | 32'hFFFF_FF00;
            if (c_op == OP_LH && c_ld[15]) c_ld = c_ld | 32'hFFFF_0000;
            if (c_status == ST_OK) begin
                c_val  = c_ld;
                c_dowr = 1'b1;
            end
        end else if (c_status == ST_OK && c_store) begin
            if (r_c_ea[31:2] == PUTC_ADDR[31:2]) begin
                // only the highest-addressed lane, which ends the word, is the port
                if ((c_size == SZ_BYTE && r_c_ea[1:0] == 2'd3) ||
                    (c_size == SZ_HALF && r_c_ea[1:0] == 2'd2) ||
                    (c_size == SZ_WORD)) begin
                    c_putc = 1'b1;
                end else c_status = ST_ADDR;
            end else if (!r_c_data_ok) begin
                c_status = ST_ADDR;
            end else begin
                c_mem_st = 1'b1;
                unique case (c_size)
                    SZ_BYTE: begin
                        unique case (r_c_ea[1:0])
                            2'd0: c_stw[31:24] = r_c_b[7:0];
                            2'd1: c_stw[23:16] = r_c_b[7:0];
                            2'd2: c_stw[15:8]  = r_c_b[7:0];
                            default: c_stw[7:0] = r_c_b[7:0];
                        endcase
                    end
                    SZ_HALF: begin
                        if (r_c_ea[1]) c_stw[15:0] = r_c_b[15:0];
                        else c_stw[31:16] = r_c_b[15:0];
                    end
                    default: c_stw = r_c_b;
                endcase
            end
        end

        c_res = '0;
        if (c_status == ST_OK && c_cond_vld) begin
            if (c_link) begin
                c_dowr = 1'b1;
                c_dst  = LINK_REG;
                c_val  = r_pc + 32'd8;
            end
            if (c_cond) begin
                c_res.branch_taken = 1'b1;
                c_res.slot_addr    = r_pc + 32'd4;
                c_npc = r_pc + 32'd4 + {c_simm[29:0], 2'b00};
            end
        end

        c_fill32  = {20'd0, r_c.fill_index};
        c_fill_ok = {1'b0, c_fill32} < INST_LIM;

        if (r_c.cmd) begin
            c_res         = '0;
            c_res.next_pc = r_pc;
            c_dowr        = 1'b0;
            c_mem_st      = 1'b0;
        end else if (c_status != ST_OK) begin
            c_res.status  = c_status;
            c_res.next_pc = r_pc;
            c_dowr        = 1'b0;
            c_mem_st      = 1'b0;
        end else begin
            c_res.next_pc = c_npc;
            c_dowr        = c_dowr && (c_dst != 5'd0);
            if (c_dowr) begin
                c_res.reg_write = 1'b1;
                c_res.reg_index = c_dst;
                c_res.reg_value = c_val;
            end
            if (c_putc) begin
                c_res.char_valid = 1'b1;
                c_res.char_out   = r_c_b[7:0];
            end
        end
    end

    assign rf_we    = c_done && c_dowr;
    assign rf_waddr = c_dst;
    assign rf_wdata = c_val;
    assign im_we    = c_done && r_c.cmd && c_fill_ok;
    assign dm_we    = r_clr_busy || (c_done && c_mem_st);
    assign dm_waddr = r_clr_busy ? r_clr_idx : r_c_daddr;
    assign dm_wdata = r_clr_busy ? '0 : c_stw;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= DATA_BASE_RST;
            r_inst_base <= INST_BASE_RST;
            r_pc        <= PC_RST;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_rvld      <= '0;
            r_fw_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DATA_BASE: r_data_base <= i_cfg_data;
                    CFG_INST_BASE: r_inst_base <= i_cfg_data;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == DAW'(DATA_WORDS - 1)) r_clr_busy <= 1'b0;
            end
            r_b_valid <= in_acc;
            if (r_b_valid) r_c_valid <= 1'b1;
            else if (c_done) r_c_valid <= 1'b0;
            if (c_done) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (c_done && !r_c.cmd && c_status == ST_OK) r_pc <= c_npc;
            if (rf_we) begin
                r_rvld[c_dst] <= 1'b1;
                r_fw_vld      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_b <= i_in;
        if (r_b_valid) begin
            r_c         <= r_b;
            r_c_a       <= b_a;
            r_c_b       <= b_b;
            r_c_ea      <= b_ea;
            r_c_data_ok <= b_data_ok;
            r_c_inst_ok <= b_inst_ok;
            r_c_daddr   <= b_off_d[DAW+1:2];
        end
        if (c_done) r_out <= c_res;
        if (rf_we) begin
            r_fw_idx <= c_dst;
            r_fw_val <= c_val;
        end
    end

    // ---------------- assertions ----------------
    a_accept_empty_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_b_valid)
        else $error("item accepted while stage B busy");

    a_b_to_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |=> r_c_valid)
        else $error("stage B item did not move to stage C");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("input ready during memory clear");

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (rf_waddr != 5'd0))
        else $error("write to register zero");

    a_store_not_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && r_c_valid) |-> !c_mem_st || !c_done)
        else $error("store overlaps memory clear");

endmodule
`default_nettype wire
